/* design/ricp_pkg.sv */
package ricp_pkg;

  localparam int NB_MAX = 8;
  localparam int NR_MAX = 14;
  localparam int KEY_ROWS = NR_MAX + 1;
  localparam int ROW_AW = $clog2(KEY_ROWS);
  localparam int DEF_MAX_COLUMNS = 8;
  localparam int DEF_MAX_ROUNDS = 14;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_KEY_LENGTH   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_BLOCK_LENGTH = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEY_PART_0   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY_PART_1   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_KEY_PART_2   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_KEY_PART_3   = 3'd5;

  localparam logic [1:0] LEN_128 = 2'd0;
  localparam logic [1:0] LEN_192 = 2'd1;

  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef logic [NB_MAX-1:0][31:0] word_row_t;

  typedef struct packed {
    logic        action;
    logic [63:0] data_0;
    logic [63:0] data_1;
    logic [63:0] data_2;
    logic [63:0] data_3;
  } in_t;

  typedef struct packed {
    logic [63:0] result_0;
    logic [63:0] result_1;
    logic [63:0] result_2;
    logic [63:0] result_3;
  } out_t;

  typedef struct packed {
    logic              load;
    logic              first;
    logic              round;
    logic              out_load;
    logic              dec;
    logic              last;
    logic [ROW_AW-1:0] row;
  } dp_cmd_t;

  function automatic logic [3:0] words_of(input logic [1:0] code);
    logic [3:0] w;
    case (code)
      LEN_128: w = 4'd4;
      LEN_192: w = 4'd6;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] rounds_of(input logic [1:0] kcode, input logic [1:0] bcode);
    logic [3:0] nk;
    logic [3:0] nb;
    nk = words_of(kcode);
    nb = words_of(bcode);
    return (nk > nb ? nk : nb) + 4'd6;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'd99,8'd124,8'd119,8'd123,8'd242,8'd107,8'd111,8'd197,
    8'd48,8'd1,8'd103,8'd43,8'd254,8'd215,8'd171,8'd118,
    8'd202,8'd130,8'd201,8'd125,8'd250,8'd89,8'd71,8'd240,
    8'd173,8'd212,8'd162,8'd175,8'd156,8'd164,8'd114,8'd192,
    8'd183,8'd253,8'd147,8'd38,8'd54,8'd63,8'd247,8'd204,
    8'd52,8'd165,8'd229,8'd241,8'd113,8'd216,8'd49,8'd21,
    8'd4,8'd199,8'd35,8'd195,8'd24,8'd150,8'd5,8'd154,
    8'd7,8'd18,8'd128,8'd226,8'd235,8'd39,8'd178,8'd117,
    8'd9,8'd131,8'd44,8'd26,8'd27,8'd110,8'd90,8'd160,
    8'd82,8'd59,8'd214,8'd179,8'd41,8'd227,8'd47,8'd132,
    8'd83,8'd209,8'd0,8'd237,8'd32,8'd252,8'd177,8'd91,
    8'd106,8'd203,8'd190,8'd57,8'd74,8'd76,8'd88,8'd207,
    8'd208,8'd239,8'd170,8'd251,8'd67,8'd77,8'd51,8'd133,
    8'd69,8'd249,8'd2,8'd127,8'd80,8'd60,8'd159,8'd168,
    8'd81,8'd163,8'd64,8'd143,8'd146,8'd157,8'd56,8'd245,
    8'd188,8'd182,8'd218,8'd33,8'd16,8'd255,8'd243,8'd210,
    8'd205,8'd12,8'd19,8'd236,8'd95,8'd151,8'd68,8'd23,
    8'd196,8'd167,8'd126,8'd61,8'd100,8'd93,8'd25,8'd115,
    8'd96,8'd129,8'd79,8'd220,8'd34,8'd42,8'd144,8'd136,
    8'd70,8'd238,8'd184,8'd20,8'd222,8'd94,8'd11,8'd219,
    8'd224,8'd50,8'd58,8'd10,8'd73,8'd6,8'd36,8'd92,
    8'd194,8'd211,8'd172,8'd98,8'd145,8'd149,8'd228,8'd121,
    8'd231,8'd200,8'd55,8'd109,8'd141,8'd213,8'd78,8'd169,
    8'd108,8'd86,8'd244,8'd234,8'd101,8'd122,8'd174,8'd8,
    8'd186,8'd120,8'd37,8'd46,8'd28,8'd166,8'd180,8'd198,
    8'd232,8'd221,8'd116,8'd31,8'd75,8'd189,8'd139,8'd138,
    8'd112,8'd62,8'd181,8'd102,8'd72,8'd3,8'd246,8'd14,
    8'd97,8'd53,8'd87,8'd185,8'd134,8'd193,8'd29,8'd158,
    8'd225,8'd248,8'd152,8'd17,8'd105,8'd217,8'd142,8'd148,
    8'd155,8'd30,8'd135,8'd233,8'd206,8'd85,8'd40,8'd223,
    8'd140,8'd161,8'd137,8'd13,8'd191,8'd230,8'd66,8'd104,
    8'd65,8'd153,8'd45,8'd15,8'd176,8'd84,8'd187,8'd22
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'd82,8'd9,8'd106,8'd213,8'd48,8'd54,8'd165,8'd56,
    8'd191,8'd64,8'd163,8'd158,8'd129,8'd243,8'd215,8'd251,
    8'd124,8'd227,8'd57,8'd130,8'd155,8'd47,8'd255,8'd135,
    8'd52,8'd142,8'd67,8'd68,8'd196,8'd222,8'd233,8'd203,
    8'd84,8'd123,8'd148,8'd50,8'd166,8'd194,8'd35,8'd61,
    8'd238,8'd76,8'd149,8'd11,8'd66,8'd250,8'd195,8'd78,
    8'd8,8'd46,8'd161,8'd102,8'd40,8'd217,8'd36,8'd178,
    8'd118,8'd91,8'd162,8'd73,8'd109,8'd139,8'd209,8'd37,
    8'd114,8'd248,8'd246,8'd100,8'd134,8'd104,8'd152,8'd22,
    8'd212,8'd164,8'd92,8'd204,8'd93,8'd101,8'd182,8'd146,
    8'd108,8'd112,8'd72,8'd80,8'd253,8'd237,8'd185,8'd218,
    8'd94,8'd21,8'd70,8'd87,8'd167,8'd141,8'd157,8'd132,
    8'd144,8'd216,8'd171,8'd0,8'd140,8'd188,8'd211,8'd10,
    8'd247,8'd228,8'd88,8'd5,8'd184,8'd179,8'd69,8'd6,
    8'd208,8'd44,8'd30,8'd143,8'd202,8'd63,8'd15,8'd2,
    8'd193,8'd175,8'd189,8'd3,8'd1,8'd19,8'd138,8'd107,
    8'd58,8'd145,8'd17,8'd65,8'd79,8'd103,8'd220,8'd234,
    8'd151,8'd242,8'd207,8'd206,8'd240,8'd180,8'd230,8'd115,
    8'd150,8'd172,8'd116,8'd34,8'd231,8'd173,8'd53,8'd133,
    8'd226,8'd249,8'd55,8'd232,8'd28,8'd117,8'd223,8'd110,
    8'd71,8'd241,8'd26,8'd113,8'd29,8'd41,8'd197,8'd137,
    8'd111,8'd183,8'd98,8'd14,8'd170,8'd24,8'd190,8'd27,
    8'd252,8'd86,8'd62,8'd75,8'd198,8'd210,8'd121,8'd32,
    8'd154,8'd219,8'd192,8'd254,8'd120,8'd205,8'd90,8'd244,
    8'd31,8'd221,8'd168,8'd51,8'd136,8'd7,8'd199,8'd49,
    8'd177,8'd18,8'd16,8'd89,8'd39,8'd128,8'd236,8'd95,
    8'd96,8'd81,8'd127,8'd169,8'd25,8'd181,8'd74,8'd13,
    8'd45,8'd229,8'd122,8'd159,8'd147,8'd201,8'd156,8'd239,
    8'd160,8'd224,8'd59,8'd77,8'd174,8'd42,8'd245,8'd176,
    8'd200,8'd235,8'd187,8'd60,8'd131,8'd83,8'd153,8'd97,
    8'd23,8'd43,8'd4,8'd126,8'd186,8'd119,8'd214,8'd38,
    8'd225,8'd105,8'd20,8'd99,8'd85,8'd33,8'd12,8'd125
  };

endpackage

/* design/ricp_ram.sv */
module ricp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ricp_keyexp.sv */
module ricp_keyexp
  import ricp_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROUNDS = DEF_MAX_ROUNDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic [1:0]        key_length,
  input  logic [1:0]        block_length,
  input  logic [3:0][63:0]  key_part,
  output logic              busy,
  output logic              we,
  output logic [ROW_AW-1:0] waddr,
  output word_row_t         wdata
);

  localparam int KEY_WORDS = MAX_COLUMNS * (MAX_ROUNDS + 1);
  localparam int IW = $clog2(KEY_WORDS + 1);

  logic [IW-1:0]     idx;
  logic [2:0]        col;
  logic [ROW_AW-1:0] row;
  logic [2:0]        kmod;
  logic [7:0]        rc;
  logic [NB_MAX-1:0][31:0] win;
  word_row_t         rowbuf;

  logic [3:0]  nk;
  logic [3:0]  nb;
  logic [3:0]  nr;
  logic [7:0]  full;
  logic [IW-1:0] total;
  logic [63:0] part;
  logic [31:0] prev;
  logic [31:0] tmp;
  logic [31:0] word;
  logic        last_col;
  logic        last_word;
  word_row_t   rowbuf_next;

  always_comb begin
    nk = words_of(key_length);
    nb = words_of(block_length);
    nr = rounds_of(key_length, block_length);
    full = {4'd0, nb} * ({4'd0, nr} + 8'd1);
    total = (32'(full) < KEY_WORDS) ? IW'(full) : IW'(KEY_WORDS);
    part = key_part[idx[2:1]];
    prev = win[0];
    tmp = prev;
    if (kmod == 3'd0) begin
      tmp = {SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]], SBOX[prev[31:24]]}
            ^ {rc, 24'd0};
    end else if (nk == 4'd8 && kmod == 3'd4) begin
      tmp = {SBOX[prev[31:24]], SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]]};
    end
    if (idx < IW'(nk)) begin
      word = idx[0] ? part[31:0] : part[63:32];
    end else begin
      word = win[nk[2:0] - 3'd1] ^ tmp;
    end
    last_col = (col == nb[2:0] - 3'd1);
    last_word = (idx == total - IW'(1));
    rowbuf_next = rowbuf;
    rowbuf_next[col] = word;
  end

  assign we = busy && (last_col || last_word);
  assign waddr = row;
  assign wdata = rowbuf_next;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b1;
      idx <= '0;
      col <= '0;
      row <= '0;
      kmod <= '0;
      rc <= RCON_FIRST;
    end else if (busy) begin
      idx <= idx + IW'(1);
      col <= last_col ? 3'd0 : col + 3'd1;
      row <= last_col ? row + ROW_AW'(1) : row;
      kmod <= (kmod == nk[2:0] - 3'd1) ? 3'd0 : kmod + 3'd1;
      if (idx >= IW'(nk) && kmod == 3'd0) begin
        rc <= xtime(rc);
      end
      if (last_word) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rowbuf <= rowbuf_next;
      win <= {win[NB_MAX-2:0], word};
    end
  end

endmodule

/* design/ricp_ctrl.sv */
module ricp_ctrl
  import ricp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic              exp_busy,
  input  logic [3:0]        nr,
  output logic              out_valid,
  input  logic              out_ready,
  output dp_cmd_t           cmd,
  output logic [ROW_AW-1:0] raddr
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_KEY   = 4'b0010,
    S_ROUND = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ROW_AW-1:0] krow;
  logic [ROW_AW-1:0] krow_next;
  logic              dec;
  logic [ROW_AW-1:0] step;
  logic              last;

  always_comb begin
    step = dec ? krow - ROW_AW'(1) : krow + ROW_AW'(1);
    last = dec ? (krow == '0) : (krow == ROW_AW'(nr));
    in_ready = (state == S_IDLE) && !exp_busy;
    state_next = state;
    krow_next = krow;
    cmd = '0;
    cmd.dec = dec;
    cmd.row = krow;
    cmd.last = last;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          krow_next = action ? ROW_AW'(nr) : '0;
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        cmd.first = 1'b1;
        krow_next = step;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (last) begin
          state_next = S_DONE;
        end else begin
          krow_next = step;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    raddr = krow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      krow <= '0;
      dec <= 1'b0;
    end else begin
      state <= state_next;
      krow <= krow_next;
      if (cmd.load) begin
        dec <= action;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/ricp_datapath.sv */
module ricp_datapath
  import ricp_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROUNDS = DEF_MAX_ROUNDS
) (
  input  logic       clk,
  input  dp_cmd_t    cmd,
  input  in_t        din,
  input  logic [1:0] block_length,
  input  word_row_t  rk,
  output out_t       result
);

  localparam int KEY_WORDS = MAX_COLUMNS * (MAX_ROUNDS + 1);

  function automatic word_row_t shift_rows(input word_row_t s, input logic [3:0] n,
                                           input logic inv);
    word_row_t t;
    int off;
    int src;
    t = s;
    for (int r = 1; r < 4; r++) begin
      off = (n == 4'd8 && r > 1) ? r + 1 : r;
      for (int c = 0; c < NB_MAX; c++) begin
        if (c < int'(n)) begin
          if (inv) begin
            src = (c >= off) ? c - off : c + int'(n) - off;
          end else begin
            src = (c + off >= int'(n)) ? c + off - int'(n) : c + off;
          end
          t[c][31-8*r -: 8] = s[src[2:0]][31-8*r -: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic word_row_t sub_bytes(input word_row_t s, input logic inv);
    word_row_t t;
    for (int c = 0; c < NB_MAX; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c][8*r +: 8] = inv ? INV_SBOX[s[c][8*r +: 8]] : SBOX[s[c][8*r +: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_fwd(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x [4];
    logic [31:0] o;
    for (int r = 0; r < 4; r++) begin
      a[r] = w[31-8*r -: 8];
      x[r] = xtime(a[r]);
    end
    for (int r = 0; r < 4; r++) begin
      o[31-8*r -: 8] = x[r] ^ x[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
    end
    return o;
  endfunction

  function automatic logic [31:0] mix_inv(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    logic [31:0] o;
    for (int r = 0; r < 4; r++) begin
      a[r] = w[31-8*r -: 8];
      x2 = xtime(a[r]);
      x4 = xtime(x2);
      x8 = xtime(x4);
      m9[r] = x8 ^ a[r];
      mb[r] = x8 ^ x2 ^ a[r];
      md[r] = x8 ^ x4 ^ a[r];
      me[r] = x8 ^ x4 ^ x2;
    end
    for (int r = 0; r < 4; r++) begin
      o[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
    end
    return o;
  endfunction

  word_row_t  st;
  word_row_t  st_next;
  word_row_t  rkm;
  word_row_t  s1;
  word_row_t  s2;
  word_row_t  s3;
  logic [3:0] nb;
  logic [7:0] base;
  out_t       res_next;

  always_comb begin
    nb = words_of(block_length);
    base = {4'd0, cmd.row} * {4'd0, nb};
    for (int c = 0; c < NB_MAX; c++) begin
      rkm[c] = ({1'b0, base} + 9'(c) < 9'(KEY_WORDS)) ? rk[c] : 32'd0;
    end
    if (!cmd.dec) begin
      s1 = sub_bytes(st, 1'b0);
      s2 = shift_rows(s1, nb, 1'b0);
      for (int c = 0; c < NB_MAX; c++) begin
        s3[c] = (cmd.last ? s2[c] : mix_fwd(s2[c])) ^ rkm[c];
      end
    end else begin
      s1 = shift_rows(st, nb, 1'b1);
      s2 = sub_bytes(s1, 1'b1);
      for (int c = 0; c < NB_MAX; c++) begin
        s3[c] = cmd.last ? (s2[c] ^ rkm[c]) : mix_inv(s2[c] ^ rkm[c]);
      end
    end
    st_next = st;
    if (cmd.load) begin
      st_next = {din.data_3[31:0], din.data_3[63:32], din.data_2[31:0], din.data_2[63:32],
                 din.data_1[31:0], din.data_1[63:32], din.data_0[31:0], din.data_0[63:32]};
    end else if (cmd.first) begin
      st_next = st ^ rkm;
    end else if (cmd.round) begin
      st_next = s3;
    end
    res_next.result_0 = {st[0], (nb > 4'd1) ? st[1] : 32'd0};
    res_next.result_1 = {st[2], st[3]};
    res_next.result_2 = (nb > 4'd4) ? {st[4], st[5]} : 64'd0;
    res_next.result_3 = (nb > 4'd6) ? {st[6], st[7]} : 64'd0;
  end

  always_ff @(posedge clk) begin
    st <= st_next;
    if (cmd.out_load) begin
      result <= res_next;
    end
  end

endmodule

/* design/rijndael_block_cipher.sv */
// a block is taken in S_IDLE only; S_KEY adds the first round key, S_ROUND runs nr rounds
// (nr = 10, 12 or 14), one per cycle, and S_DONE loads the result once the output is free
// key schedule: after reset and each write to a defined register the round key memory is
// rebuilt one 32-bit word per cycle, nb*(nr+1) words (at most 120), no block taken meanwhile
// reset: synchronous, clears the registers to a 128-bit zero key and 128-bit block
module rijndael_block_cipher
  import ricp_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROUNDS = DEF_MAX_ROUNDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_item
);

  logic [1:0]        key_length;
  logic [1:0]        block_length;
  logic [3:0][63:0]  key_part;
  logic              restart;
  logic              exp_busy;
  logic              we;
  logic [ROW_AW-1:0] waddr;
  word_row_t         wdata;
  logic [ROW_AW-1:0] raddr;
  word_row_t         rk;
  dp_cmd_t           cmd;

  always_comb begin
    case (cfg_index)
      REG_KEY_LENGTH, REG_BLOCK_LENGTH, REG_KEY_PART_0,
      REG_KEY_PART_1, REG_KEY_PART_2, REG_KEY_PART_3: restart = cfg_write;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= LEN_128;
      block_length <= LEN_128;
      key_part <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_LENGTH:   key_length <= cfg_data[1:0];
        REG_BLOCK_LENGTH: block_length <= cfg_data[1:0];
        REG_KEY_PART_0:   key_part[0] <= cfg_data;
        REG_KEY_PART_1:   key_part[1] <= cfg_data;
        REG_KEY_PART_2:   key_part[2] <= cfg_data;
        REG_KEY_PART_3:   key_part[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  ricp_keyexp #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_keyexp (
    .clk(clk),
    .rst(rst),
    .restart(restart),
    .key_length(key_length),
    .block_length(block_length),
    .key_part(key_part),
    .busy(exp_busy),
    .we(we),
    .waddr(waddr),
    .wdata(wdata)
  );

  ricp_ram #(
    .WIDTH(NB_MAX * 32),
    .DEPTH(KEY_ROWS)
  ) u_ram (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rk)
  );

  ricp_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(in_item.action),
    .exp_busy(exp_busy),
    .nr(rounds_of(key_length, block_length)),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd(cmd),
    .raddr(raddr)
  );

  ricp_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_datapath (
    .clk(clk),
    .cmd(cmd),
    .din(in_item),
    .block_length(block_length),
    .rk(rk),
    .result(out_item)
  );

endmodule

/* verif/tb_rijndael_block_cipher.sv */
module tb_rijndael_block_cipher;
  import ricp_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [63:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_item;

  rijndael_block_cipher uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #5 clk = ~clk;

  in_t         pending_blocks[$];
  out_t        expected_blocks[$];
  int          err_count = 0;
  int          send_wait = 0;
  int          recv_wait = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  // cipher state mirrored in the testbench
  logic [1:0]  key_len;
  logic [1:0]  blk_len;
  logic [63:0] key_word [4];
  logic [31:0] sched [120];

  function automatic int nwords(logic [1:0] code);
    return code == LEN_128 ? 4 : (code == LEN_192 ? 6 : 8);
  endfunction

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic void build_schedule();
    int nk, nb, nr, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = nwords(key_len);
    nb = nwords(blk_len);
    nr = (nk > nb ? nk : nb) + 6;
    total = nb * (nr + 1);
    rc = 8'h01;
    for (int i = 0; i < total; i++) begin
      if (i < nk) begin
        sched[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
      end else begin
        t = sched[i - 1];
        if (i % nk == 0) begin
          t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = gf_double(rc);
        end else if (nk > 6 && i % nk == 4) begin
          t = sub_word(t);
        end
        sched[i] = sched[i - nk] ^ t;
      end
    end
  endfunction

  function automatic void add_rk(ref logic [7:0] s [4][8], input int nb, input int rnd);
    logic [31:0] w;
    for (int c = 0; c < nb; c++) begin
      w = sched[rnd * nb + c];
      for (int r = 0; r < 4; r++) s[r][c] ^= w[31 - 8 * r -: 8];
    end
  endfunction

  function automatic void sub_state(ref logic [7:0] s [4][8], input int nb, input bit inv);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < nb; c++) s[r][c] = inv ? INV_SBOX[s[r][c]] : SBOX[s[r][c]];
  endfunction

  function automatic void shift_state(ref logic [7:0] s [4][8], input int nb, input bit inv);
    logic [7:0] tmp [8];
    int off;
    for (int r = 1; r < 4; r++) begin
      off = (nb == 8 && r > 1) ? r + 1 : r;
      for (int c = 0; c < nb; c++) begin
        if (inv) tmp[(c + off) % nb] = s[r][c];
        else tmp[c] = s[r][(c + off) % nb];
      end
      for (int c = 0; c < nb; c++) s[r][c] = tmp[c];
    end
  endfunction

  function automatic void mix_state(ref logic [7:0] s [4][8], input int nb, input bit inv);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] v;
    if (inv) begin
      m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    end else begin
      m = '{8'h02, 8'h03, 8'h01, 8'h01};
    end
    for (int c = 0; c < nb; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[r][c];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gf_mul(a[k], m[(k + 4 - r) & 3]);
        s[r][c] = v;
      end
    end
  endfunction

  function automatic out_t cipher_block(in_t d);
    logic [7:0] s [4][8];
    logic [63:0] din [4];
    logic [63:0] dout [4];
    logic [31:0] w;
    int nk, nb, nr;
    out_t o;
    nk = nwords(key_len);
    nb = nwords(blk_len);
    nr = (nk > nb ? nk : nb) + 6;
    din = '{d.data_0, d.data_1, d.data_2, d.data_3};
    for (int c = 0; c < nb; c++) begin
      w = c[0] ? din[c >> 1][31:0] : din[c >> 1][63:32];
      for (int r = 0; r < 4; r++) s[r][c] = w[31 - 8 * r -: 8];
    end
    if (!d.action) begin
      add_rk(s, nb, 0);
      for (int rnd = 1; rnd < nr; rnd++) begin
        sub_state(s, nb, 1'b0);
        shift_state(s, nb, 1'b0);
        mix_state(s, nb, 1'b0);
        add_rk(s, nb, rnd);
      end
      sub_state(s, nb, 1'b0);
      shift_state(s, nb, 1'b0);
      add_rk(s, nb, nr);
    end else begin
      add_rk(s, nb, nr);
      shift_state(s, nb, 1'b1);
      sub_state(s, nb, 1'b1);
      for (int rnd = nr - 1; rnd > 0; rnd--) begin
        add_rk(s, nb, rnd);
        mix_state(s, nb, 1'b1);
        shift_state(s, nb, 1'b1);
        sub_state(s, nb, 1'b1);
      end
      add_rk(s, nb, 0);
    end
    dout = '{64'h0, 64'h0, 64'h0, 64'h0};
    for (int c = 0; c < nb; c++) begin
      w = {s[0][c], s[1][c], s[2][c], s[3][c]};
      if (c[0]) dout[c >> 1][31:0] = w;
      else dout[c >> 1][63:32] = w;
    end
    o.result_0 = dout[0];
    o.result_1 = dout[1];
    o.result_2 = dout[2];
    o.result_3 = dout[3];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // driver
  always @(posedge clk) begin
    logic busy;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        expected_blocks.push_back(cipher_block(in_item));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_blocks.size() > 0) begin
          in_item <= pending_blocks.pop_front();
          busy = 1'b1;
          send_wait = no_idle ? 0 : $urandom_range(0, 9);
        end
      end
      in_valid <= busy;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          report("unexpected beat", out_item.result_0, 64'h0);
        end else begin
          want = expected_blocks.pop_front();
          if (out_item.result_0 !== want.result_0)
            report("result_0", out_item.result_0, want.result_0);
          if (out_item.result_1 !== want.result_1)
            report("result_1", out_item.result_1, want.result_1);
          if (out_item.result_2 !== want.result_2)
            report("result_2", out_item.result_2, want.result_2);
          if (out_item.result_3 !== want.result_3)
            report("result_3", out_item.result_3, want.result_3);
        end
        recv_wait = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (hold_req) begin
        recv_wait = 400;
        hold_req = 1'b0;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_KEY_LENGTH:   key_len = val[1:0];
      REG_BLOCK_LENGTH: blk_len = val[1:0];
      REG_KEY_PART_0:   key_word[0] = val;
      REG_KEY_PART_1:   key_word[1] = val;
      REG_KEY_PART_2:   key_word[2] = val;
      REG_KEY_PART_3:   key_word[3] = val;
      default: ;
    endcase
    build_schedule();
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0);
    repeat (24) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_t rand_block();
    in_t b;
    b.action = 1'($urandom_range(0, 1));
    b.data_0 = rand64();
    b.data_1 = rand64();
    b.data_2 = rand64();
    b.data_3 = rand64();
    return b;
  endfunction

  initial begin
    logic [63:0] kv;
    key_len = LEN_128;
    blk_len = LEN_128;
    for (int i = 0; i < 4; i++) key_word[i] = 64'h0;
    build_schedule();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all-zero key at reset, extreme data in both directions
    for (int a = 0; a < 2; a++) begin
      pending_blocks.push_back('{a[0], 64'h0, 64'h0, 64'h0, 64'h0});
      pending_blocks.push_back('{a[0], '1, '1, '1, '1});
      pending_blocks.push_back('{a[0], {4{16'haaaa}}, {4{16'h5555}}, '1, 64'h0});
      pending_blocks.push_back('{a[0], 64'h0011223344556677, 64'h8899aabbccddeeff,
                                 rand64(), rand64()});
    end
    wait_drained();

    for (int p = 0; p < 16; p++) begin
      no_idle = (p % 4 == 3);
      write_reg(REG_KEY_LENGTH, {62'(p), 2'(p % 4)});
      write_reg(REG_BLOCK_LENGTH, {62'($urandom), 2'(p / 4)});
      for (int k = 0; k < 4; k++) begin
        kv = (p == 1) ? '1 : (p == 2) ? 64'h0 : rand64();
        write_reg(CFG_AW'(REG_KEY_PART_0 + k), kv);
      end
      if (p == 5) begin
        write_reg(CFG_AW'(6), rand64());
        write_reg(CFG_AW'(7), rand64());
      end
      @(posedge clk);
      cfg_write <= 1'b0;
      if (p == 7) hold_req = 1'b1;
      if (p == 2) begin
        pending_blocks.push_back('{1'b0, '1, '1, '1, '1});
        pending_blocks.push_back('{1'b1, 64'h0, 64'h0, 64'h0, 64'h0});
      end
      for (int n = 0; n < 75; n++) pending_blocks.push_back(rand_block());
      wait_drained();
    end

    if (err_count == 0) begin
      $display("rijndael_block_cipher regression: pass");
    end else begin
      $display("rijndael_block_cipher regression: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("rijndael_block_cipher regression: fail");
    $finish;
  end

endmodule

/* files.f */
design/ricp_pkg.sv
design/ricp_ram.sv
design/ricp_keyexp.sv
design/ricp_ctrl.sv
design/ricp_datapath.sv
design/rijndael_block_cipher.sv
verif/tb_rijndael_block_cipher.sv
